// ===== hw/rtl/hssc_pkg.sv =====
// Package for the hall six-step commutator: word types, register indexes,
// reset values and the commutation and kick pattern tables.
// Used by every module of the block; depends on nothing.
package hssc_pkg;

	// Input word: one loop tick or one hall edge event.
	typedef struct packed {
		logic       opcode;
		logic [2:0] hall_levels;
		logic [1:0] edge_line;
		logic [7:0] throttle;
	} item_t;

	// Result word: the commutator state after the item.
	typedef struct packed {
		logic [2:0] high_enable;
		logic [2:0] low_enable;
		logic [7:0] compare_a;
		logic [7:0] compare_b;
		logic       running;
		logic       kicked;
	} result_t;

	// Configuration register file contents.
	typedef struct packed {
		logic       direction;
		logic [9:0] stall_limit;
		logic [7:0] duty_floor;
		logic [7:0] kick_threshold;
		logic [3:0] dead_offset;
	} cfg_t;

	typedef struct packed {
		logic [2:0] high;
		logic [2:0] low;
	} gates_t;

	typedef enum logic [2:0] {
		REG_DIRECTION      = 3'd0,
		REG_STALL_LIMIT    = 3'd1,
		REG_DUTY_FLOOR     = 3'd2,
		REG_KICK_THRESHOLD = 3'd3,
		REG_DEAD_OFFSET    = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_EDGE = 1'b1
	} opcode_t;

	localparam int CFG_IDX_W = 3;

	localparam logic       DIRECTION_RST      = 1'b1;
	localparam logic [9:0] STALL_LIMIT_RST    = 10'd1000;
	localparam logic [7:0] DUTY_FLOOR_RST     = 8'd20;
	localparam logic [7:0] KICK_THRESHOLD_RST = 8'd150;
	localparam logic [3:0] DEAD_OFFSET_RST    = 4'd10;

	localparam logic [7:0] CMP_A_RST = 8'd220;
	localparam logic [7:0] CMP_B_RST = 8'd210;

	// Duty is (DUTY_BASE - THR_GAIN * throttle) / 10. The division by ten is a
	// multiply by 6554 and a 16-bit shift, exact for dividends below 16384.
	localparam logic [12:0] DUTY_BASE   = 13'd2500;
	localparam logic [12:0] THR_GAIN    = 13'd22;
	localparam logic [24:0] DIV10_MUL   = 25'd6554;
	localparam int          DIV10_SHIFT = 16;

	localparam logic [2:0] GATE_NONE = 3'b000;
	localparam logic [2:0] GATE_U    = 3'b001;
	localparam logic [2:0] GATE_V    = 3'b010;
	localparam logic [2:0] GATE_W    = 3'b100;

	localparam logic [1:0] LINE_HALL1 = 2'd0;
	localparam logic [1:0] LINE_HALL2 = 2'd1;
	localparam logic [1:0] LINE_HALL3 = 2'd2;

	// Phase pair driven after an edge on a hall line, given the line's new
	// level. An edge on the unused line code drives nothing.
	function automatic gates_t edge_gates(input logic dir, input logic [1:0] line,
			input logic [2:0] hall);
		gates_t g;
		logic   lvl;
		g   = '{high: GATE_NONE, low: GATE_NONE};
		lvl = 1'b0;
		case (line)
			LINE_HALL1: lvl = hall[0];
			LINE_HALL2: lvl = hall[1];
			LINE_HALL3: lvl = hall[2];
			default:    lvl = 1'b0;
		endcase
		case ({dir, line, lvl})
			{1'b0, LINE_HALL1, 1'b0}: g = '{high: GATE_U, low: GATE_W};
			{1'b0, LINE_HALL1, 1'b1}: g = '{high: GATE_W, low: GATE_U};
			{1'b0, LINE_HALL2, 1'b0}: g = '{high: GATE_V, low: GATE_U};
			{1'b0, LINE_HALL2, 1'b1}: g = '{high: GATE_U, low: GATE_V};
			{1'b0, LINE_HALL3, 1'b0}: g = '{high: GATE_W, low: GATE_V};
			{1'b0, LINE_HALL3, 1'b1}: g = '{high: GATE_V, low: GATE_W};
			{1'b1, LINE_HALL1, 1'b0}: g = '{high: GATE_V, low: GATE_W};
			{1'b1, LINE_HALL1, 1'b1}: g = '{high: GATE_W, low: GATE_V};
			{1'b1, LINE_HALL2, 1'b0}: g = '{high: GATE_W, low: GATE_U};
			{1'b1, LINE_HALL2, 1'b1}: g = '{high: GATE_U, low: GATE_W};
			{1'b1, LINE_HALL3, 1'b0}: g = '{high: GATE_U, low: GATE_V};
			{1'b1, LINE_HALL3, 1'b1}: g = '{high: GATE_V, low: GATE_U};
			default: g = '{high: GATE_NONE, low: GATE_NONE};
		endcase
		return g;
	endfunction

	// Start-up kick pattern for a hall position. All-low and all-high
	// positions are invalid and drive nothing.
	function automatic gates_t kick_gates(input logic dir, input logic [2:0] hall);
		gates_t g;
		case ({dir, hall})
			{1'b0, 3'd1}: g = '{high: GATE_V, low: GATE_U};
			{1'b0, 3'd2}: g = '{high: GATE_W, low: GATE_V};
			{1'b0, 3'd3}: g = '{high: GATE_W, low: GATE_U};
			{1'b0, 3'd4}: g = '{high: GATE_U, low: GATE_W};
			{1'b0, 3'd5}: g = '{high: GATE_V, low: GATE_W};
			{1'b0, 3'd6}: g = '{high: GATE_U, low: GATE_V};
			{1'b1, 3'd1}: g = '{high: GATE_U, low: GATE_V};
			{1'b1, 3'd2}: g = '{high: GATE_V, low: GATE_W};
			{1'b1, 3'd3}: g = '{high: GATE_U, low: GATE_W};
			{1'b1, 3'd4}: g = '{high: GATE_W, low: GATE_U};
			{1'b1, 3'd5}: g = '{high: GATE_W, low: GATE_V};
			{1'b1, 3'd6}: g = '{high: GATE_V, low: GATE_U};
			default:      g = '{high: GATE_NONE, low: GATE_NONE};
		endcase
		return g;
	endfunction

endpackage

// ===== hw/rtl/hssc_cfg.sv =====
// Configuration register file of the hall six-step commutator.
// Depends on hssc_pkg for the register index codes and reset values.
module hssc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [9:0]                     cfg_data,
	output hssc_pkg::cfg_t                 cfg
);

	hssc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction      <= hssc_pkg::DIRECTION_RST;
			cfg_q.stall_limit    <= hssc_pkg::STALL_LIMIT_RST;
			cfg_q.duty_floor     <= hssc_pkg::DUTY_FLOOR_RST;
			cfg_q.kick_threshold <= hssc_pkg::KICK_THRESHOLD_RST;
			cfg_q.dead_offset    <= hssc_pkg::DEAD_OFFSET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				hssc_pkg::REG_DIRECTION:      cfg_q.direction      <= cfg_data[0];
				hssc_pkg::REG_STALL_LIMIT:    cfg_q.stall_limit    <= cfg_data[9:0];
				hssc_pkg::REG_DUTY_FLOOR:     cfg_q.duty_floor     <= cfg_data[7:0];
				hssc_pkg::REG_KICK_THRESHOLD: cfg_q.kick_threshold <= cfg_data[7:0];
				hssc_pkg::REG_DEAD_OFFSET:    cfg_q.dead_offset    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/hssc_core.sv =====
// Commutation state and its combinational update for one word.
// Depends on hssc_pkg for the word types, constants and pattern tables.
module hssc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  hssc_pkg::cfg_t    cfg,
	input  hssc_pkg::item_t   item,
	input  logic              step,
	output hssc_pkg::result_t result
);

	logic [9:0] stall_count_q;
	logic       run_q;
	logic [2:0] high_q;
	logic [2:0] low_q;
	logic [7:0] cmp_a_q;
	logic [7:0] cmp_b_q;

	logic [9:0] stall_count_d;
	logic       run_d;
	logic [2:0] high_d;
	logic [2:0] low_d;
	logic [7:0] cmp_a_d;
	logic [7:0] cmp_b_d;
	logic       kicked_d;

	logic [12:0]      thr_x22;
	logic             duty_neg;
	logic [11:0]      duty_num;
	logic [24:0]      duty_prod;
	logic [7:0]       duty_quot;
	logic [7:0]       duty;
	logic [9:0]       cnt_adv;
	logic             run_adv;
	hssc_pkg::gates_t edge_g;
	hssc_pkg::gates_t kick_g;

	// Throttle to compare value; a throttle that drives the numerator below
	// zero lands on the floor like any other small result.
	always_comb begin
		thr_x22   = 13'(item.throttle) * hssc_pkg::THR_GAIN;
		duty_neg  = thr_x22 > hssc_pkg::DUTY_BASE;
		duty_num  = 12'(hssc_pkg::DUTY_BASE - thr_x22);
		duty_prod = 25'(duty_num) * hssc_pkg::DIV10_MUL;
		duty_quot = duty_prod[hssc_pkg::DIV10_SHIFT +: 8];
		duty      = (duty_neg || duty_quot < cfg.duty_floor) ? cfg.duty_floor : duty_quot;
	end

	assign edge_g = hssc_pkg::edge_gates(cfg.direction, item.edge_line, item.hall_levels);
	assign kick_g = hssc_pkg::kick_gates(cfg.direction, item.hall_levels);

	always_comb begin
		stall_count_d = stall_count_q;
		run_d         = run_q;
		high_d        = high_q;
		low_d         = low_q;
		cmp_a_d       = cmp_a_q;
		cmp_b_d       = cmp_b_q;
		kicked_d      = 1'b0;
		cnt_adv       = (stall_count_q < cfg.stall_limit) ? stall_count_q + 10'd1
			: stall_count_q;
		run_adv       = cnt_adv < cfg.stall_limit;

		if (item.opcode == hssc_pkg::OP_EDGE) begin
			stall_count_d = '0;
			high_d        = edge_g.high;
			low_d         = edge_g.low;
		end else begin
			if (run_q) begin
				cmp_a_d = duty;
				cmp_b_d = (duty > 8'(cfg.dead_offset)) ? duty - 8'(cfg.dead_offset) : 8'd0;
			end else begin
				high_d = hssc_pkg::GATE_NONE;
				low_d  = hssc_pkg::GATE_NONE;
			end
			stall_count_d = cnt_adv;
			run_d         = run_adv;
			// A stopped motor with a low enough duty gets a kick: the high side is
			// replaced unless the hall position is invalid, the low side gains the kick phase.
			if (!run_adv && duty < cfg.kick_threshold) begin
				high_d        = (kick_g.high != hssc_pkg::GATE_NONE) ? kick_g.high : high_d;
				low_d         = low_d | kick_g.low;
				run_d         = 1'b1;
				stall_count_d = '0;
				kicked_d      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_count_q <= '0;
			run_q         <= 1'b0;
			high_q        <= hssc_pkg::GATE_NONE;
			low_q         <= hssc_pkg::GATE_NONE;
			cmp_a_q       <= hssc_pkg::CMP_A_RST;
			cmp_b_q       <= hssc_pkg::CMP_B_RST;
		end else if (step) begin
			stall_count_q <= stall_count_d;
			run_q         <= run_d;
			high_q        <= high_d;
			low_q         <= low_d;
			cmp_a_q       <= cmp_a_d;
			cmp_b_q       <= cmp_b_d;
		end
	end

	assign result = '{high_enable: high_d, low_enable: low_d, compare_a: cmp_a_d,
		compare_b: cmp_b_d, running: run_d, kicked: kicked_d};

endmodule

// ===== hw/rtl/hall_six_step_commutator_top.sv =====
// Hall six-step commutator. Every accepted word (a loop tick or a hall edge)
// yields exactly one result word holding the gate enables, both PWM compare
// values, the run flag and a kick flag. One word is taken per clock cycle while
// results are taken; a word waits in the input register until the result
// register is free or being emptied, and the commutation state is updated as it
// moves on; its result is then offered from the result register, so throughput
// is set only by how quickly results are taken. Configuration writes are taken
// in any cycle and should be made only while no word is in flight.
// Depends on hssc_pkg, hssc_cfg and hssc_core.
module hall_six_step_commutator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  hssc_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output hssc_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [9:0]                     cfg_data
);

	hssc_pkg::cfg_t    cfg;
	hssc_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              advance;
	hssc_pkg::result_t result_d;
	hssc_pkg::result_t result_q;
	logic              result_valid_q;

	// The input stage moves on whenever the result register is free or is
	// being emptied in the same cycle.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	hssc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hssc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (advance),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/hssc_checker.sv =====
// Port-level checks for the hall six-step commutator, bound to its top level.
// Depends on hssc_pkg for the word types.
module hssc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input hssc_pkg::result_t result
);

	// A kick always leaves the motor marked as running.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kicked |-> result.running)
		else $error("kick reported without the motor running");

	// Never more than one high-side gate is on.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0(result.high_enable))
		else $error("more than one high-side gate enabled");

	// Compare B never exceeds compare A.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.compare_b <= result.compare_a)
		else $error("compare B above compare A");

	// A stalled result word holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed or dropped while stalled");

endmodule

bind hall_six_step_commutator_top hssc_checker u_hssc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== dv/hall_six_step_commutator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the hall six-step commutator: directed and random tick and edge words,
// with a word-level prediction of gates, compares and run state checked against every result.
// Depends on hssc_pkg and hall_six_step_commutator_top.
module hall_six_step_commutator_top_test;

	// Keeps its own copy of the commutation state and the registers and works out the
	// result word that every accepted input word should produce.
	class commutation_tracker;
		bit                  direction;
		bit [9:0]            stall_limit;
		bit [7:0]            duty_floor;
		bit [7:0]            kick_threshold;
		bit [3:0]            dead_offset;
		bit [9:0]            stall_count;
		bit                  run_flag;
		bit [2:0]            high_gates;
		bit [2:0]            low_gates;
		bit [7:0]            cmp_a;
		bit [7:0]            cmp_b;
		bit [5:0]            edge_pat [2][6];
		bit [5:0]            kick_pat [2][8];
		hssc_pkg::result_t   gate_states_due [$];
		int                  mismatches;

		function new();
			direction      = hssc_pkg::DIRECTION_RST;
			stall_limit    = hssc_pkg::STALL_LIMIT_RST;
			duty_floor     = hssc_pkg::DUTY_FLOOR_RST;
			kick_threshold = hssc_pkg::KICK_THRESHOLD_RST;
			dead_offset    = hssc_pkg::DEAD_OFFSET_RST;
			stall_count    = '0;
			run_flag       = 1'b0;
			high_gates     = hssc_pkg::GATE_NONE;
			low_gates      = hssc_pkg::GATE_NONE;
			cmp_a          = hssc_pkg::CMP_A_RST;
			cmp_b          = hssc_pkg::CMP_B_RST;
			mismatches     = 0;
			// {high, low} pairs indexed by line and new level of that line.
			edge_pat = '{
				'{{hssc_pkg::GATE_U, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_W}},
				'{{hssc_pkg::GATE_V, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_U}}};
			kick_pat = '{
				'{{hssc_pkg::GATE_NONE, hssc_pkg::GATE_NONE},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_NONE, hssc_pkg::GATE_NONE}},
				'{{hssc_pkg::GATE_NONE, hssc_pkg::GATE_NONE},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_U, hssc_pkg::GATE_W},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_W, hssc_pkg::GATE_V},
				  {hssc_pkg::GATE_V, hssc_pkg::GATE_U},
				  {hssc_pkg::GATE_NONE, hssc_pkg::GATE_NONE}}};
		endfunction

		function void set_register(hssc_pkg::cfg_idx_t idx, bit [9:0] val);
			case (idx)
				hssc_pkg::REG_DIRECTION:      direction      = val[0];
				hssc_pkg::REG_STALL_LIMIT:    stall_limit    = val;
				hssc_pkg::REG_DUTY_FLOOR:     duty_floor     = val[7:0];
				hssc_pkg::REG_KICK_THRESHOLD: kick_threshold = val[7:0];
				hssc_pkg::REG_DEAD_OFFSET:    dead_offset    = val[3:0];
				default: ;
			endcase
		endfunction

		function void take_word(hssc_pkg::item_t w);
			hssc_pkg::result_t r;
			int                v;
			int                pos;
			bit [7:0]          duty;
			bit [5:0]          pat;
			r.kicked = 1'b0;
			if (w.opcode == hssc_pkg::OP_EDGE) begin
				stall_count = '0;
				high_gates  = hssc_pkg::GATE_NONE;
				low_gates   = hssc_pkg::GATE_NONE;
				if (w.edge_line <= hssc_pkg::LINE_HALL3) begin
					pos        = int'(w.edge_line) * 2 + int'(w.hall_levels[w.edge_line]);
					pat        = edge_pat[direction][pos];
					high_gates = pat[5:3];
					low_gates  = pat[2:0];
				end
			end else begin
				v = 2500 - 22 * int'(w.throttle);
				if (v < 0 || v / 10 < int'(duty_floor))
					duty = duty_floor;
				else
					duty = 8'(v / 10);
				if (run_flag) begin
					cmp_a = duty;
					cmp_b = (duty > dead_offset) ? duty - dead_offset : 8'd0;
				end else begin
					high_gates = hssc_pkg::GATE_NONE;
					low_gates  = hssc_pkg::GATE_NONE;
				end
				if (stall_count < stall_limit)
					stall_count = stall_count + 10'd1;
				run_flag = (stall_count < stall_limit);
				if (!run_flag && duty < kick_threshold) begin
					// Invalid hall positions leave the gates alone but still count as a kick.
					pat        = kick_pat[direction][w.hall_levels];
					if (pat != '0) begin
						high_gates = pat[5:3];
						low_gates  = low_gates | pat[2:0];
					end
					run_flag    = 1'b1;
					stall_count = '0;
					r.kicked    = 1'b1;
				end
			end
			r.high_enable = high_gates;
			r.low_enable  = low_gates;
			r.compare_a   = cmp_a;
			r.compare_b   = cmp_b;
			r.running     = run_flag;
			gate_states_due.push_back(r);
		endfunction

		function string show(hssc_pkg::result_t r);
			return $sformatf("high=%0d low=%0d cmp_a=%0d cmp_b=%0d running=%0b kicked=%0b",
				r.high_enable, r.low_enable, r.compare_a, r.compare_b, r.running, r.kicked);
		endfunction

		function void check_word(hssc_pkg::result_t got);
			hssc_pkg::result_t want;
			string             bad;
			bad = "";
			if (gate_states_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result word with nothing expected: %s", show(got));
				return;
			end
			want = gate_states_due.pop_front();
			if (got.high_enable !== want.high_enable) bad = {bad, " high_enable"};
			if (got.low_enable !== want.low_enable)   bad = {bad, " low_enable"};
			if (got.compare_a !== want.compare_a)     bad = {bad, " compare_a"};
			if (got.compare_b !== want.compare_b)     bad = {bad, " compare_b"};
			if (got.running !== want.running)         bad = {bad, " running"};
			if (got.kicked !== want.kicked)           bad = {bad, " kicked"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR at %0t:%s differ\n  expected %s\n  actual   %s",
						$realtime, bad, show(want), show(got));
			end
		endfunction

		function int outstanding();
			return gate_states_due.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n       = 1'b0;
	logic                           item_valid   = 1'b0;
	logic                           item_ready;
	hssc_pkg::item_t                item         = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	hssc_pkg::result_t              result;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [hssc_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [9:0]                     cfg_data     = '0;

	bit                             steady = 1'b0;
	bit [2:0]                       hall_cycle [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
	int                             hall_pos = 0;
	commutation_tracker             tracker;

	hall_six_step_commutator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= steady || ($urandom_range(99) >= 19);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_word(result);
	end

	function automatic hssc_pkg::item_t make_word(hssc_pkg::opcode_t op, bit [2:0] hall,
			bit [1:0] line, bit [7:0] thr);
		hssc_pkg::item_t w;
		w.opcode      = op;
		w.hall_levels = hall;
		w.edge_line   = line;
		w.throttle    = thr;
		return w;
	endfunction

	// Valid is only lowered during an idle gap or when draining, so a word that follows
	// straight on keeps valid high without a second assignment in the same step.
	task automatic send_word(hssc_pkg::item_t w);
		while (!steady && $urandom_range(99) < 19) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		tracker.take_word(w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(hssc_pkg::cfg_idx_t idx, bit [9:0] val);
		if (!cfg_valid)
			cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_register(idx, val);
	endtask

	task automatic set_config(bit dir, bit [9:0] limit, bit [7:0] floor_val,
			bit [7:0] kick_val, bit [3:0] dead_val);
		drain();
		write_reg(hssc_pkg::REG_DIRECTION, {9'd0, dir});
		write_reg(hssc_pkg::REG_STALL_LIMIT, limit);
		write_reg(hssc_pkg::REG_DUTY_FLOOR, {2'd0, floor_val});
		write_reg(hssc_pkg::REG_KICK_THRESHOLD, {2'd0, kick_val});
		write_reg(hssc_pkg::REG_DEAD_OFFSET, {6'd0, dead_val});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Moves the rotor one hall state on and sends the edge of the line that changed.
	task automatic send_hall_step();
		bit [2:0] prev;
		bit [2:0] diff;
		bit [1:0] line;
		prev     = hall_cycle[hall_pos];
		hall_pos = $urandom_range(1) ? (hall_pos + 1) % 6 : (hall_pos + 5) % 6;
		diff     = prev ^ hall_cycle[hall_pos];
		line     = diff[0] ? hssc_pkg::LINE_HALL1 :
			(diff[1] ? hssc_pkg::LINE_HALL2 : hssc_pkg::LINE_HALL3);
		send_word(make_word(hssc_pkg::OP_EDGE, hall_cycle[hall_pos], line, 8'($urandom)));
	endtask

	initial begin
		int        count;
		int        burst;
		int        cap;
		bit [9:0]  limit;
		bit [7:0]  floor_val;
		bit [7:0]  kick_val;
		bit [3:0]  dead_val;
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: duty extremes, the throttle wrap, edges on every line and the
		// unused line code.
		send_word(make_word(hssc_pkg::OP_TICK, 3'd1, hssc_pkg::LINE_HALL1, 8'd0));
		send_word(make_word(hssc_pkg::OP_TICK, 3'd6, 2'd3, 8'd255));
		send_word(make_word(hssc_pkg::OP_EDGE, 3'd7, hssc_pkg::LINE_HALL1, 8'd0));
		send_word(make_word(hssc_pkg::OP_EDGE, 3'd0, hssc_pkg::LINE_HALL2, 8'd255));
		send_word(make_word(hssc_pkg::OP_EDGE, 3'd5, hssc_pkg::LINE_HALL3, 8'd0));
		send_word(make_word(hssc_pkg::OP_EDGE, 3'd7, 2'd3, 8'd170));
		send_word(make_word(hssc_pkg::OP_TICK, 3'd2, hssc_pkg::LINE_HALL1, 8'd113));

		// A zero stall limit keeps the motor stopped, so every tick kicks, including at
		// the invalid hall positions; compare B runs out of headroom and saturates.
		set_config(1'b0, 10'd0, 8'd10, 8'd255, 4'd10);
		for (int h = 0; h < 8; h++)
			send_word(make_word(hssc_pkg::OP_TICK, 3'(h), 2'(h), 8'd255));
		send_word(make_word(hssc_pkg::OP_EDGE, 3'd3, 2'd3, 8'd0));

		set_config(1'b1, 10'd1023, 8'd250, 8'd0, 4'd0);
		send_word(make_word(hssc_pkg::OP_TICK, 3'd4, hssc_pkg::LINE_HALL2, 8'd0));
		send_word(make_word(hssc_pkg::OP_TICK, 3'd4, hssc_pkg::LINE_HALL2, 8'd255));
		send_word(make_word(hssc_pkg::OP_EDGE, 3'd4, hssc_pkg::LINE_HALL3, 8'd0));
		send_word(make_word(hssc_pkg::OP_TICK, 3'd5, hssc_pkg::LINE_HALL3, 8'd200));

		for (int p = 0; p < 8; p++) begin
			limit     = (p == 0) ? 10'd1 : (p == 1) ? 10'd1023 : (p == 5) ? 10'd0 :
				10'($urandom_range(1, 24));
			floor_val = (p % 2 == 0) ? 8'd10 : (p == 3) ? 8'd250 :
				8'($urandom_range(10, 250));
			kick_val  = (p == 2) ? 8'd0 : (p == 4) ? 8'd255 : 8'($urandom_range(100, 255));
			dead_val  = (p == 0) ? 4'd0 : (p == 1) ? 4'd10 : 4'($urandom_range(10));
			set_config(1'($urandom_range(1)), limit, floor_val, kick_val, dead_val);
			steady = (p == 3);
			cap    = (limit <= 10'd30) ? int'(limit) + 3 : 40;
			count  = 0;
			while (count < 212) begin
				if ($urandom_range(99) < 15) begin
					send_word(hssc_pkg::item_t'($urandom));
					count++;
				end else begin
					burst = $urandom_range(cap);
					repeat (burst)
						send_word(make_word(hssc_pkg::OP_TICK, hall_cycle[hall_pos],
							2'($urandom), 8'($urandom)));
					send_hall_step();
					count += burst + 1;
				end
			end
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
